### rtl/bmpp_pkg.sv
// ----------------------------------------------------------------------------
// bmpp_pkg
// Shared types and constants of the 24-bit bitmap pixel stream parser.
// ----------------------------------------------------------------------------
package bmpp_pkg;

	localparam int DefMaxWidth  = 4096;
	localparam int DefMaxHeight = 4096;

	localparam logic [5:0] HdrBytes    = 6'd54;
	localparam logic [5:0] HdrWidthLo  = 6'd18;
	localparam logic [5:0] HdrWidthHi  = 6'd21;
	localparam logic [5:0] HdrHeightLo = 6'd22;
	localparam logic [5:0] HdrHeightHi = 6'd25;
	localparam logic [5:0] HdrMagic0   = 6'd0;
	localparam logic [5:0] HdrMagic1   = 6'd1;
	localparam logic [7:0] MagicB      = 8'h42;
	localparam logic [7:0] MagicM      = 8'h4d;

	localparam logic ErrMagic = 1'b0;
	localparam logic ErrSize  = 1'b1;

	typedef enum logic [1:0] {
		RK_PIXEL  = 2'd0,
		RK_HEADER = 2'd1,
		RK_ERROR  = 2'd2
	} res_kind_t;

	typedef struct packed {
		res_kind_t   result_kind;
		logic        error_code;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [11:0] column;
		logic [11:0] row;
		logic [12:0] image_width;
		logic [12:0] image_height;
		logic        last_pixel;
	} bmpp_res_t;

endpackage

### rtl/bmpp_if.sv
// ----------------------------------------------------------------------------
// bmpp_if
// Valid/ready channels of the bitmap parser: file bytes in, results out.
// ----------------------------------------------------------------------------
interface bmpp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       first_byte;

	modport source (output valid, data_byte, first_byte, input ready);
	modport sink   (input valid, data_byte, first_byte, output ready);
endinterface

interface bmpp_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  result_kind;
	logic        error_code;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [11:0] column;
	logic [11:0] row;
	logic [12:0] image_width;
	logic [12:0] image_height;
	logic        last_pixel;

	modport source (output valid, result_kind, error_code, red, green, blue, column, row,
		image_width, image_height, last_pixel, input ready);
	modport sink   (input valid, result_kind, error_code, red, green, blue, column, row,
		image_width, image_height, last_pixel, output ready);
endinterface

### rtl/bmpp_parse.sv
// ----------------------------------------------------------------------------
// bmpp_parse
// Header and pixel parsing state machine; one byte per accepted request.
// ----------------------------------------------------------------------------
module bmpp_parse
	import bmpp_pkg::*;
#(
	parameter int MAX_WIDTH  = DefMaxWidth,
	parameter int MAX_HEIGHT = DefMaxHeight
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	output logic       res_vld,
	output bmpp_res_t  res
);

	localparam int CW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH + 1)  : 1;
	localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT + 1) : 1;

	typedef enum logic [2:0] {
		M_IDLE, M_HEADER, M_PIXELS, M_PAD, M_DONE
	} mode_t;

	mode_t          mode_q, mode_d;
	logic [5:0]     idx_q, idx_d;
	logic [31:0]    wid_q, wid_d, hgt_q, hgt_d;
	logic [CW-1:0]  col_q, col_d;
	logic [RW-1:0]  row_q, row_d;
	logic [1:0]     phase_q, phase_d;
	logic [7:0]     blue_q, blue_d, green_q, green_d;
	logic [1:0]     pad_q, pad_d;

	always_comb begin
		mode_t         cur;
		logic [5:0]    idx;
		logic [5:0]    idx_inc;
		logic [1:0]    lane;
		logic [CW-1:0] col_inc;
		logic [RW-1:0] row_inc;
		logic          row_end;
		logic          img_end;

		cur     = first_byte ? M_HEADER : mode_q;
		idx     = first_byte ? 6'd0 : idx_q;
		idx_inc = idx + 6'd1;
		col_inc = col_q + 1'b1;
		row_inc = row_q + 1'b1;
		row_end = (col_inc == wid_q[CW-1:0]);
		img_end = (row_inc == hgt_q[RW-1:0]);
		lane    = '0;

		mode_d  = mode_q;
		idx_d   = idx_q;
		wid_d   = first_byte ? 32'd0 : wid_q;
		hgt_d   = first_byte ? 32'd0 : hgt_q;
		col_d   = col_q;
		row_d   = row_q;
		phase_d = phase_q;
		blue_d  = blue_q;
		green_d = green_q;
		pad_d   = pad_q;
		if (first_byte) begin
			mode_d  = M_HEADER;
			idx_d   = '0;
			col_d   = '0;
			row_d   = '0;
			phase_d = '0;
			blue_d  = '0;
			green_d = '0;
			pad_d   = '0;
		end

		res_vld = 1'b0;
		res     = '0;

		case (cur)
			M_HEADER: begin
				if ((idx == HdrMagic0 && data_byte != MagicB) ||
						(idx == HdrMagic1 && data_byte != MagicM)) begin
					res_vld          = 1'b1;
					res.result_kind  = RK_ERROR;
					res.error_code   = ErrMagic;
					mode_d           = M_DONE;
				end else begin
					if (idx >= HdrWidthLo && idx <= HdrWidthHi) begin
						lane = 2'(idx - HdrWidthLo);
						wid_d[8*lane +: 8] = data_byte;
					end else if (idx >= HdrHeightLo && idx <= HdrHeightHi) begin
						lane = 2'(idx - HdrHeightLo);
						hgt_d[8*lane +: 8] = data_byte;
					end
					idx_d = idx_inc;
					if (idx_inc == HdrBytes) begin
						res_vld = 1'b1;
						if (wid_d > 32'(MAX_WIDTH) || hgt_d > 32'(MAX_HEIGHT)) begin
							res.result_kind = RK_ERROR;
							res.error_code  = ErrSize;
							mode_d          = M_DONE;
						end else begin
							res.result_kind  = RK_HEADER;
							res.image_width  = wid_d[12:0];
							res.image_height = hgt_d[12:0];
							col_d   = '0;
							row_d   = '0;
							phase_d = '0;
							mode_d  = (wid_d == 32'd0 || hgt_d == 32'd0) ? M_DONE : M_PIXELS;
						end
					end
				end
			end
			M_PIXELS: begin
				case (phase_q)
					2'd0: begin
						blue_d  = data_byte;
						phase_d = 2'd1;
					end
					2'd1: begin
						green_d = data_byte;
						phase_d = 2'd2;
					end
					default: begin
						phase_d         = 2'd0;
						res_vld         = 1'b1;
						res.result_kind = RK_PIXEL;
						res.red         = data_byte;
						res.green       = green_q;
						res.blue        = blue_q;
						res.column      = 12'(col_q);
						res.row         = 12'(row_q);
						res.last_pixel  = row_end && img_end;
						col_d           = col_inc;
						if (row_end) begin
							pad_d = wid_q[1:0];
							col_d = '0;
							if (img_end) begin
								mode_d = M_DONE;
							end else if (wid_q[1:0] != 2'd0) begin
								mode_d = M_PAD;
							end else begin
								row_d = row_inc;
							end
						end
					end
				endcase
			end
			M_PAD: begin
				pad_d = pad_q - 2'd1;
				if (pad_q == 2'd1) begin
					row_d  = row_inc;
					col_d  = '0;
					mode_d = M_PIXELS;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_IDLE;
			idx_q   <= '0;
			wid_q   <= '0;
			hgt_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			phase_q <= '0;
			blue_q  <= '0;
			green_q <= '0;
			pad_q   <= '0;
		end else if (take) begin
			mode_q  <= mode_d;
			idx_q   <= idx_d;
			wid_q   <= wid_d;
			hgt_q   <= hgt_d;
			col_q   <= col_d;
			row_q   <= row_d;
			phase_q <= phase_d;
			blue_q  <= blue_d;
			green_q <= green_d;
			pad_q   <= pad_d;
		end
	end

endmodule

### rtl/bmpp_out_buf.sv
// ----------------------------------------------------------------------------
// bmpp_out_buf
// Result register with a skid stage that takes one more result while the output stalls.
// ----------------------------------------------------------------------------
module bmpp_out_buf
	import bmpp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  bmpp_res_t push_res,
	output logic      space,
	output logic      head_vld,
	output bmpp_res_t head_res,
	input  logic      pop_rdy
);

	logic      head_vld_q, skid_vld_q;
	bmpp_res_t head_q, skid_q;
	logic      pop;

	assign space    = !skid_vld_q;
	assign head_vld = head_vld_q;
	assign head_res = head_q;
	assign pop      = head_vld_q && pop_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (pop) begin
			if (skid_vld_q) begin
				skid_vld_q <= 1'b0;
			end else begin
				head_vld_q <= push;
			end
		end else if (push) begin
			if (!head_vld_q) begin
				head_vld_q <= 1'b1;
			end else begin
				skid_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_vld_q) begin
				head_q <= skid_q;
			end else if (push) begin
				head_q <= push_res;
			end
		end else if (push) begin
			if (!head_vld_q) begin
				head_q <= push_res;
			end else begin
				skid_q <= push_res;
			end
		end
	end

endmodule

### rtl/bmp24_pixel_stream_parser.sv
// ----------------------------------------------------------------------------
// bmp24_pixel_stream_parser
// Parses a 24-bit uncompressed bitmap byte stream into header, error and
// pixel results.
// ----------------------------------------------------------------------------
// One file byte is taken per clock while the result buffer has space, and any
// result it causes is registered into the buffer's head or skid slot. The
// per-byte work is a handful of counters and compares. A two-slot result
// buffer sits on the output, and byte requests are refused only while both
// slots hold results the consumer has not yet taken.
module bmp24_pixel_stream_parser
	import bmpp_pkg::*;
#(
	parameter int MAX_WIDTH  = DefMaxWidth,
	parameter int MAX_HEIGHT = DefMaxHeight
) (
	input  logic      clk,
	input  logic      arst_n,
	bmpp_byte_if.sink bytes,
	bmpp_res_if.source results
);

	logic      take;
	logic      res_vld;
	logic      space;
	bmpp_res_t res;
	bmpp_res_t head;

	assign bytes.ready = space;
	assign take        = bytes.valid && space;

	bmpp_parse #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.data_byte  (bytes.data_byte),
		.first_byte (bytes.first_byte),
		.res_vld    (res_vld),
		.res        (res)
	);

	bmpp_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take && res_vld),
		.push_res (res),
		.space    (space),
		.head_vld (results.valid),
		.head_res (head),
		.pop_rdy  (results.ready)
	);

	assign results.result_kind  = head.result_kind;
	assign results.error_code   = head.error_code;
	assign results.red          = head.red;
	assign results.green        = head.green;
	assign results.blue         = head.blue;
	assign results.column       = head.column;
	assign results.row          = head.row;
	assign results.image_width  = head.image_width;
	assign results.image_height = head.image_height;
	assign results.last_pixel   = head.last_pixel;

endmodule
